### src/dnw_pkg.sv
// Package for the date normalise and weekday unit.
// Holds the sequencer state type, the result bundle, widths and calendar tables.
// Depends on nothing; every other file imports it.
`default_nettype none

package dnw_pkg;

  localparam int DAY_IN_W  = 12;
  localparam int MONTH_W   = 4;
  localparam int YEAR_W    = 14;
  localparam int DAY_OUT_W = 5;
  localparam int WDAY_W    = 3;

  // Internal working width: the year may carry past its 14-bit port range.
  localparam int ACC_W   = 15;
  localparam int YMOD_W  = 9;
  localparam int STEP_W  = 4;

  localparam int MONTHS_PER_YEAR = 12;
  localparam int LEAP_CYCLE      = 400;
  localparam int CENTURY         = 100;
  localparam int WEEK_LEN        = 7;

  // Restoring reduction schedules: highest shift of each divisor.
  localparam logic [STEP_W-1:0] YEAR_TOP_SHIFT = STEP_W'(5);
  localparam logic [STEP_W-1:0] CENT_TOP_SHIFT = STEP_W'(1);
  localparam logic [STEP_W-1:0] WEEK_TOP_SHIFT = STEP_W'(8);

  localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(11);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_YMOD,
    ST_NORM,
    ST_CENT,
    ST_SUM,
    ST_WEEK,
    ST_DONE
  } dnw_state_t;

  typedef struct packed {
    logic [DAY_OUT_W-1:0] day;
    logic [MONTH_W-1:0]   month;
    logic [YEAR_W-1:0]    year;
    logic [WDAY_W-1:0]    weekday;
  } dnw_result_t;

  function automatic logic [DAY_OUT_W-1:0] days_in_month(input logic [MONTH_W-1:0] m,
                                                          input logic leap);
    logic [DAY_OUT_W-1:0] d;
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: d = DAY_OUT_W'(31);
      4'd3, 4'd5, 4'd8, 4'd10:                   d = DAY_OUT_W'(30);
      4'd1:                                      d = leap ? DAY_OUT_W'(29) : DAY_OUT_W'(28);
      default:                                   d = DAY_OUT_W'(31);
    endcase
    return d;
  endfunction

  // Days in a common year before the first of the given month.
  function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // Leap test from the year taken modulo 400.
  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    return (ymod[1:0] == 2'b00) && (ymod != YMOD_W'(100)) &&
           (ymod != YMOD_W'(200)) && (ymod != YMOD_W'(300));
  endfunction

endpackage

`default_nettype wire

### src/dnw_sub_unit.sv
// Shared compare and subtract unit of the date normalise and weekday unit.
// Gives a - b and whether a is at least b. Depends on dnw_pkg.
`default_nettype none

module dnw_sub_unit (
  input  wire logic [dnw_pkg::ACC_W-1:0] a,
  input  wire logic [dnw_pkg::ACC_W-1:0] b,
  output logic                           ge,
  output logic [dnw_pkg::ACC_W-1:0]      diff
);
  import dnw_pkg::*;

  logic [ACC_W:0] wide;

  assign wide = {1'b0, a} - {1'b0, b};
  assign ge   = ~wide[ACC_W];
  assign diff = wide[ACC_W-1:0];

endmodule

`default_nettype wire

### src/dnw_core.sv
// Sequencer and datapath of the date normalise and weekday unit.
// Drives one shared subtractor through year reduction, normalisation, century reduction and modulo 7.
// Depends on dnw_pkg and dnw_sub_unit.
`default_nettype none

module dnw_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [dnw_pkg::DAY_IN_W-1:0]   day_in,
  input  wire logic [dnw_pkg::MONTH_W-1:0]    month_in,
  input  wire logic [dnw_pkg::YEAR_W-1:0]     year_in,
  input  wire logic                           res_free,
  output logic                                busy,
  output logic                                res_load,
  output dnw_pkg::dnw_result_t                res
);
  import dnw_pkg::*;

  dnw_state_t             state_r, state_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [DAY_IN_W-1:0]    day_r, day_nxt;
  logic [MONTH_W-1:0]     month_r, month_nxt;
  logic [ACC_W-1:0]       year_r, year_nxt;
  logic [YMOD_W-1:0]      ymod_r, ymod_nxt;
  logic [YMOD_W-1:0]      rfull_r, rfull_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;

  logic [ACC_W-1:0]       sub_b;
  logic                   sub_ge;
  logic [ACC_W-1:0]       sub_diff;
  logic                   leap;
  logic [DAY_OUT_W-1:0]   dlen;
  logic                   over;
  logic                   last_step;
  logic [ACC_W-1:0]       week_sum;

  dnw_sub_unit u_sub (
    .a    (state_r == ST_NORM ? ACC_W'(day_r) : acc_r),
    .b    (sub_b),
    .ge   (sub_ge),
    .diff (sub_diff)
  );

  assign leap      = is_leap(ymod_r);
  assign dlen      = days_in_month(month_r, leap);
  assign over      = sub_ge && (sub_diff != '0);
  assign last_step = (step_r == '0);

  always_comb begin
    case (state_r)
      ST_YMOD: sub_b = ACC_W'(LEAP_CYCLE) << step_r;
      ST_NORM: sub_b = ACC_W'(dlen);
      ST_CENT: sub_b = ACC_W'(CENTURY) << step_r;
      ST_WEEK: sub_b = ACC_W'(WEEK_LEN) << step_r;
      default: sub_b = '0;
    endcase
  end

  // Gauss first-day term plus days elapsed; acc holds (year - 1) mod 100 here.
  assign week_sum = ACC_W'(1) + ACC_W'(5) * ACC_W'(acc_r[1:0]) + (acc_r << 2)
                  + ACC_W'(6) * ACC_W'(rfull_r) + ACC_W'(days_before(month_r))
                  + ACC_W'(leap && (month_r > FEBRUARY)) + ACC_W'(day_r) + ACC_W'(6);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_YMOD;
      ST_YMOD: if (last_step) state_nxt = ST_NORM;
      ST_NORM: if (!over) state_nxt = ST_CENT;
      ST_CENT: if (last_step) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_WEEK;
      ST_WEEK: if (last_step) state_nxt = ST_DONE;
      ST_DONE: if (res_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath updates.
  always_comb begin
    step_nxt  = step_r;
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    ymod_nxt  = ymod_r;
    rfull_nxt = rfull_r;
    acc_nxt   = acc_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          day_nxt   = day_in;
          month_nxt = (month_in >= MONTH_W'(MONTHS_PER_YEAR))
                      ? month_in - MONTH_W'(MONTHS_PER_YEAR) : month_in;
          year_nxt  = ACC_W'(year_in);
          acc_nxt   = ACC_W'(year_in);
          step_nxt  = YEAR_TOP_SHIFT;
        end
      end
      ST_YMOD: begin
        if (sub_ge) acc_nxt = sub_diff;
        step_nxt = step_r - STEP_W'(1);
        if (last_step) ymod_nxt = sub_ge ? sub_diff[YMOD_W-1:0] : acc_r[YMOD_W-1:0];
      end
      ST_NORM: begin
        if (over) begin
          day_nxt = sub_diff[DAY_IN_W-1:0];
          if (month_r == DECEMBER) begin
            month_nxt = '0;
            year_nxt  = year_r + ACC_W'(1);
            ymod_nxt  = (ymod_r == YMOD_W'(LEAP_CYCLE - 1)) ? '0 : ymod_r + YMOD_W'(1);
          end else begin
            month_nxt = month_r + MONTH_W'(1);
          end
        end else begin
          // Year minus one, modulo 400; year zero gives 399.
          rfull_nxt = (ymod_r == '0) ? YMOD_W'(LEAP_CYCLE - 1) : ymod_r - YMOD_W'(1);
          acc_nxt   = (ymod_r == '0) ? ACC_W'(LEAP_CYCLE - 1) : ACC_W'(ymod_r - YMOD_W'(1));
          step_nxt  = CENT_TOP_SHIFT;
        end
      end
      ST_CENT: begin
        if (sub_ge) acc_nxt = sub_diff;
        step_nxt = step_r - STEP_W'(1);
      end
      ST_SUM: begin
        acc_nxt  = week_sum;
        step_nxt = WEEK_TOP_SHIFT;
      end
      ST_WEEK: begin
        if (sub_ge) acc_nxt = sub_diff;
        step_nxt = step_r - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r  <= step_nxt;
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    ymod_r  <= ymod_nxt;
    rfull_r <= rfull_nxt;
    acc_r   <= acc_nxt;
  end

  assign busy        = (state_r != ST_IDLE);
  assign res_load    = (state_r == ST_DONE) && res_free;
  assign res.day     = day_r[DAY_OUT_W-1:0];
  assign res.month   = month_r;
  assign res.year    = year_r[YEAR_W-1:0];
  assign res.weekday = acc_r[WDAY_W-1:0];

endmodule

`default_nettype wire

### src/dnw_out_stage.sv
// Output register of the date normalise and weekday unit.
// Holds one finished result until the downstream side takes it. Depends on dnw_pkg.
`default_nettype none

module dnw_out_stage (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  load,
  input  wire dnw_pkg::dnw_result_t  res,
  input  wire logic                  out_stall,
  output logic                       free,
  output logic                       out_valid,
  output dnw_pkg::dnw_result_t       out_res
);
  import dnw_pkg::*;

  logic        valid_r, valid_nxt;
  dnw_result_t res_r;

  // The register is free when empty or when its transfer completes this cycle.
  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

### src/date_normalize_weekday_unit.sv
// Top level of the date normalise and weekday unit.
// Instantiates dnw_core and dnw_out_stage; depends on dnw_pkg.
//
//   channel  ports                                     direction
//   input    in_valid in_stall in_day in_month in_year  date to normalise
//   output   out_valid out_stall out_day out_month      normalised date
//            out_year out_weekday                       and day of week
//
// One item passes through year reduction modulo 400, one subtraction per month
// taken from the day plus a final check, the century remainder, a summing step,
// reduction modulo 7 and a hand-over; the single shared subtractor does each
// reduction. in_stall is high from acceptance until hand-over.
// Reset is synchronous, active low, and empties the sequencer and output register.
// The output register holds a result while out_stall is high; the next item
// may be accepted and worked on meanwhile.
`default_nettype none

module date_normalize_weekday_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [dnw_pkg::DAY_IN_W-1:0]   in_day,
  input  wire logic [dnw_pkg::MONTH_W-1:0]    in_month,
  input  wire logic [dnw_pkg::YEAR_W-1:0]     in_year,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [dnw_pkg::DAY_OUT_W-1:0]       out_day,
  output logic [dnw_pkg::MONTH_W-1:0]         out_month,
  output logic [dnw_pkg::YEAR_W-1:0]          out_year,
  output logic [dnw_pkg::WDAY_W-1:0]          out_weekday
);
  import dnw_pkg::*;

  logic        busy;
  logic        res_load;
  logic        res_free;
  dnw_result_t res;
  dnw_result_t out_res;

  assign in_stall = busy;

  dnw_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && !busy),
    .day_in   (in_day),
    .month_in (in_month),
    .year_in  (in_year),
    .res_free (res_free),
    .busy     (busy),
    .res_load (res_load),
    .res      (res)
  );

  dnw_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .res       (res),
    .out_stall (out_stall),
    .free      (res_free),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_day     = out_res.day;
  assign out_month   = out_res.month;
  assign out_year    = out_res.year;
  assign out_weekday = out_res.weekday;

endmodule

`default_nettype wire
